// ===== src/htq_pkg.sv =====
// Shared types and codes for the heap timer queue.
// Holds the entry and result structs, the command and result codes and the sequencer states.
// No dependencies.
package htq_pkg;

  localparam int EXP_W = 32;
  localparam int ID_W  = 31;
  localparam int CMD_W = 3;
  localparam int KIND_W = 3;

  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADJUST = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FIRE   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

  localparam logic [KIND_W-1:0] KIND_ADDED    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DELETED  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ADJUSTED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FIRED    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NOTFOUND = 3'd4;
  localparam logic [KIND_W-1:0] KIND_FULL     = 3'd5;
  localparam logic [KIND_W-1:0] KIND_NONE     = 3'd6;
  localparam logic [KIND_W-1:0] KIND_CLEARED  = 3'd7;

  typedef struct packed {
    logic [EXP_W-1:0] expiry;
    logic [ID_W-1:0]  ident;
  } entry_t;

  localparam int ENTRY_W = EXP_W + ID_W;

  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   ident;
    logic              last;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_RM_LAST,
    S_SD_LOADV,
    S_SD_CHK,
    S_SD_L,
    S_SD_R,
    S_SD_CMP,
    S_SU_LOADV,
    S_SU_CHK,
    S_SU_CMP,
    S_TK_ISSUE,
    S_TK_CHK
  } state_t;

  typedef enum logic [2:0] {
    CTX_ADD,
    CTX_ADJ_UP,
    CTX_ADJ_DN,
    CTX_RM_SD,
    CTX_RM_SU
  } ctx_t;

endpackage

// ===== src/htq_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
// A read of the address being written returns the new data. No dependencies.
module htq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/htq_seq.sv =====
// Command sequencer of the heap timer queue: id search, sift up and sift down over the heap RAM.
// Depends on htq_pkg and drives one htq_ram instance through its port.
module htq_seq #(
  parameter int CAPACITY = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [htq_pkg::CMD_W-1:0]     command,
  input  logic [htq_pkg::EXP_W-1:0]     now,
  input  logic [htq_pkg::EXP_W-1:0]     time_slot,
  input  logic [htq_pkg::ID_W-1:0]      timer_id,
  input  logic [htq_pkg::EXP_W-1:0]     new_expiry,
  output logic                          busy,
  output htq_pkg::result_t              res,
  output logic                          ram_we,
  output logic [$clog2(CAPACITY)-1:0]   ram_waddr,
  output logic [htq_pkg::ENTRY_W-1:0]   ram_wdata,
  output logic [$clog2(CAPACITY)-1:0]   ram_raddr,
  input  logic [htq_pkg::ENTRY_W-1:0]   ram_rdata
);
  import htq_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = IW + 2;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  state_t state, state_next;
  ctx_t ctx, ctx_next;
  logic [CMD_W-1:0] cmd, cmd_next;
  logic [EXP_W-1:0] held_now, held_now_next, held_nexp, held_nexp_next;
  logic [ID_W-1:0] held_id, held_id_next, idctr, idctr_next, pend, pend_next;
  logic have_pend, have_pend_next;
  entry_t v, v_next, m, m_next, rd;
  logic [IW-1:0] idx, idx_next, base, base_next, mi, mi_next, k, k_next;
  logic [CW-1:0] cnt, cnt_next, bound, bound_next;

  logic [XW-1:0] child_x, right_x, bound_x;
  logic [IW-1:0] parent;
  logic [EXP_W:0] sum;
  logic [EXP_W-1:0] add_exp;
  logic [ID_W-1:0] nid_raw, nid;
  logic [CW-1:0] rem_last;
  logic rm_go, rm_fin, sd_fin, su_fin, tick_fin;
  logic [IW-1:0] rm_pos;

  assign rd      = entry_t'(ram_rdata);
  assign child_x = XW'({idx, 1'b1});
  assign right_x = child_x + XW'(1);
  assign bound_x = XW'(bound);
  assign parent  = (idx - IW'(1)) >> 1;
  assign sum     = {1'b0, now} + {1'b0, time_slot};
  assign add_exp = sum[EXP_W] ? {EXP_W{1'b1}} : sum[EXP_W-1:0];
  assign nid_raw = idctr + ID_W'(1);
  assign nid     = (nid_raw == '0) ? ID_W'(1) : nid_raw;
  assign rem_last = cnt - CW'(1);
  assign busy    = (state != S_IDLE);

  always_comb begin
    state_next = state;
    ctx_next = ctx;
    cmd_next = cmd;
    held_now_next = held_now;
    held_nexp_next = held_nexp;
    held_id_next = held_id;
    idctr_next = idctr;
    pend_next = pend;
    have_pend_next = have_pend;
    v_next = v;
    m_next = m;
    idx_next = idx;
    base_next = base;
    mi_next = mi;
    k_next = k;
    cnt_next = cnt;
    bound_next = bound;
    ram_we = 1'b0;
    ram_waddr = idx;
    ram_wdata = v;
    ram_raddr = '0;
    res = '0;
    rm_go = 1'b0;
    rm_pos = '0;
    rm_fin = 1'b0;
    sd_fin = 1'b0;
    su_fin = 1'b0;
    tick_fin = 1'b0;

    case (state)
      S_IDLE: begin
        if (start) begin
          cmd_next = command;
          held_id_next = timer_id;
          held_now_next = now;
          held_nexp_next = new_expiry;
          have_pend_next = 1'b0;
          case (command)
            CMD_ADD: begin
              if (cnt >= CAP_C) begin
                res = '{valid: 1'b1, kind: KIND_FULL, ident: '0, last: 1'b1};
              end else begin
                idctr_next = nid;
                v_next = '{expiry: add_exp, ident: nid};
                held_id_next = nid;
                idx_next = cnt[IW-1:0];
                cnt_next = cnt + CW'(1);
                ctx_next = CTX_ADD;
                state_next = S_SU_CHK;
              end
            end
            CMD_DELETE, CMD_ADJUST, CMD_FIRE: begin
              if (cnt == '0) begin
                res = '{valid: 1'b1, kind: KIND_NOTFOUND, ident: '0, last: 1'b1};
              end else begin
                ram_raddr = '0;
                k_next = '0;
                state_next = S_SRCH;
              end
            end
            CMD_TICK: begin
              state_next = S_TK_ISSUE;
            end
            CMD_CLEAR: begin
              cnt_next = '0;
              res = '{valid: 1'b1, kind: KIND_CLEARED, ident: '0, last: 1'b1};
            end
            default: ;
          endcase
        end
      end
      S_SRCH: begin
        if (rd.ident == held_id) begin
          if (cmd == CMD_ADJUST) begin
            v_next = '{expiry: held_nexp, ident: held_id};
            idx_next = k;
            base_next = k;
            ctx_next = CTX_ADJ_UP;
            state_next = S_SU_CHK;
          end else begin
            rm_go = 1'b1;
            rm_pos = k;
          end
        end else if ((CW'(k) + CW'(1)) == cnt) begin
          res = '{valid: 1'b1, kind: KIND_NOTFOUND, ident: '0, last: 1'b1};
          state_next = S_IDLE;
        end else begin
          ram_raddr = k + IW'(1);
          k_next = k + IW'(1);
        end
      end
      S_RM_LAST: begin
        v_next = rd;
        state_next = S_SD_CHK;
      end
      S_SD_LOADV: begin
        v_next = rd;
        state_next = S_SD_CHK;
      end
      S_SD_CHK: begin
        if (child_x >= bound_x) begin
          ram_we = 1'b1;
          sd_fin = 1'b1;
        end else begin
          ram_raddr = child_x[IW-1:0];
          state_next = S_SD_L;
        end
      end
      S_SD_L: begin
        m_next = rd;
        mi_next = child_x[IW-1:0];
        if (right_x < bound_x) begin
          ram_raddr = right_x[IW-1:0];
          state_next = S_SD_R;
        end else begin
          state_next = S_SD_CMP;
        end
      end
      S_SD_R: begin
        if (rd.expiry < m.expiry) begin
          m_next = rd;
          mi_next = right_x[IW-1:0];
        end
        state_next = S_SD_CMP;
      end
      S_SD_CMP: begin
        ram_we = 1'b1;
        if (v.expiry < m.expiry) begin
          sd_fin = 1'b1;
        end else begin
          ram_wdata = m;
          idx_next = mi;
          state_next = S_SD_CHK;
        end
      end
      S_SU_LOADV: begin
        v_next = rd;
        state_next = S_SU_CHK;
      end
      S_SU_CHK: begin
        if (idx == '0) begin
          ram_we = 1'b1;
          su_fin = 1'b1;
        end else begin
          ram_raddr = parent;
          state_next = S_SU_CMP;
        end
      end
      S_SU_CMP: begin
        ram_we = 1'b1;
        if (v.expiry < rd.expiry) begin
          ram_wdata = rd;
          idx_next = parent;
          state_next = S_SU_CHK;
        end else begin
          su_fin = 1'b1;
        end
      end
      S_TK_ISSUE: begin
        if (cnt == '0) begin
          tick_fin = 1'b1;
        end else begin
          ram_raddr = '0;
          state_next = S_TK_CHK;
        end
      end
      S_TK_CHK: begin
        if (!(held_now < rd.expiry)) begin
          if (have_pend) begin
            res = '{valid: 1'b1, kind: KIND_FIRED, ident: pend, last: 1'b0};
          end
          pend_next = rd.ident;
          have_pend_next = 1'b1;
          rm_go = 1'b1;
          rm_pos = '0;
        end else begin
          tick_fin = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase

    // Start of a removal: the last entry moves into the hole and sifts down, then up.
    if (rm_go) begin
      cnt_next = rem_last;
      bound_next = rem_last;
      if (CW'(rm_pos) != rem_last) begin
        ram_raddr = rem_last[IW-1:0];
        idx_next = rm_pos;
        base_next = rm_pos;
        ctx_next = CTX_RM_SD;
        state_next = S_RM_LAST;
      end else begin
        rm_fin = 1'b1;
      end
    end

    if (sd_fin) begin
      if (ctx == CTX_RM_SD) begin
        idx_next = base;
        ram_raddr = base;
        ctx_next = CTX_RM_SU;
        state_next = S_SU_LOADV;
      end else begin
        res = '{valid: 1'b1, kind: KIND_ADJUSTED, ident: held_id, last: 1'b1};
        state_next = S_IDLE;
      end
    end

    if (su_fin) begin
      case (ctx)
        CTX_ADD: begin
          res = '{valid: 1'b1, kind: KIND_ADDED, ident: held_id, last: 1'b1};
          state_next = S_IDLE;
        end
        CTX_ADJ_UP: begin
          idx_next = base;
          ram_raddr = base;
          bound_next = cnt;
          ctx_next = CTX_ADJ_DN;
          state_next = S_SD_LOADV;
        end
        default: rm_fin = 1'b1;
      endcase
    end

    if (rm_fin) begin
      if (cmd == CMD_TICK) begin
        state_next = S_TK_ISSUE;
      end else begin
        res = '{valid: 1'b1, kind: (cmd == CMD_DELETE) ? KIND_DELETED : KIND_FIRED,
                ident: held_id, last: 1'b1};
        state_next = S_IDLE;
      end
    end

    if (tick_fin) begin
      if (have_pend) begin
        res = '{valid: 1'b1, kind: KIND_FIRED, ident: pend, last: 1'b1};
      end else begin
        res = '{valid: 1'b1, kind: KIND_NONE, ident: '0, last: 1'b1};
      end
      state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ctx <= CTX_ADD;
      cnt <= '0;
      idctr <= '0;
      have_pend <= 1'b0;
    end else begin
      state <= state_next;
      ctx <= ctx_next;
      cnt <= cnt_next;
      idctr <= idctr_next;
      have_pend <= have_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd <= cmd_next;
    held_now <= held_now_next;
    held_nexp <= held_nexp_next;
    held_id <= held_id_next;
    pend <= pend_next;
    v <= v_next;
    m <= m_next;
    idx <= idx_next;
    base <= base_next;
    mi <= mi_next;
    k <= k_next;
    bound <= bound_next;
  end

`ifndef SYNTHESIS
  a_cnt_cap: assert property (@(posedge clk) disable iff (rst) cnt <= CAP_C)
    else $error("entry count above capacity");
  a_wr_live: assert property (@(posedge clk) disable iff (rst)
      ram_we |-> (CW'(ram_waddr) < cnt))
    else $error("heap write outside live entries");
  a_srch_rng: assert property (@(posedge clk) disable iff (rst)
      (state == S_SRCH) |-> (CW'(k) < cnt))
    else $error("search index past live entries");
  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
      (state == S_IDLE && !start) |-> (!res.valid) ##1 (state == S_IDLE))
    else $error("sequencer left idle without a command");
`endif

endmodule

// ===== src/heap_timer_queue.sv =====
// Heap timer queue: a binary min-heap of timers keyed on expiry time.
// Top level; depends on htq_pkg, htq_seq and htq_ram.
//
// Usage. A command transaction is taken at a rising edge where start is high
// and busy is low; command, now, time_slot, timer_id and new_expiry are
// sampled at that edge only. Commands are add, delete, adjust, tick, fire by
// id and clear; codes 6 and 7 are taken and do nothing.
// Each result transaction is shown on kind, timer_id_res and last for exactly
// one cycle while strobe is high. The receiver cannot hold results off, so
// the block never waits on the output side. A tick gives one result per
// expired timer, in heap order, and marks the final one with last; with no
// timer due it gives a single none result. Clear gives its result in the
// cycle after acceptance; add gives its result once the new entry has sifted
// up. A command that names an id first scans the heap at one entry per
// cycle, then sifts. Sifts are paced by the single read port of the heap
// RAM, which serves one read per level going up and up to two going down.
// A tick removes each due timer from the root in turn.
// Reset clears the entry count and the id counter; the heap RAM needs no
// clearing, since only entries below the count are ever read.
module heap_timer_queue #(
  parameter int CAPACITY = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [htq_pkg::CMD_W-1:0]      command,
  input  logic [htq_pkg::EXP_W-1:0]      now,
  input  logic [htq_pkg::EXP_W-1:0]      time_slot,
  input  logic [htq_pkg::ID_W-1:0]       timer_id,
  input  logic [htq_pkg::EXP_W-1:0]      new_expiry,
  output logic                           strobe,
  output logic [htq_pkg::KIND_W-1:0]     kind,
  output logic [htq_pkg::ID_W-1:0]       timer_id_res,
  output logic                           last
);
  import htq_pkg::*;

  localparam int IW = $clog2(CAPACITY);

  result_t res;
  logic ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  // Expiry and id of each slot share one RAM word.
  htq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_heap (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  htq_seq #(
    .CAPACITY(CAPACITY)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .command   (command),
    .now       (now),
    .time_slot (time_slot),
    .timer_id  (timer_id),
    .new_expiry(new_expiry),
    .busy      (busy),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // Result register: the sequencer's result appears on the ports for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    kind <= res.kind;
    timer_id_res <= res.ident;
    last <= res.last;
  end

endmodule

// ===== tb/tb.sv =====
// Testbench for heap_timer_queue: drives command transactions and checks every result.
// Depends on htq_pkg and heap_timer_queue; carries its own heap predictor.
`timescale 1ns / 100ps

module tb;
  import htq_pkg::*;

  localparam int CAP = 64;
  localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

  // One command transaction as presented to the block.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [EXP_W-1:0] at;
    logic [EXP_W-1:0] span;
    logic [ID_W-1:0]  ident;
    logic [EXP_W-1:0] expiry;
  } command_t;

  // One result transaction.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   ident;
    logic              last;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [CMD_W-1:0] command = '0;
  logic [EXP_W-1:0] now = '0;
  logic [EXP_W-1:0] time_slot = '0;
  logic [ID_W-1:0]  timer_id = '0;
  logic [EXP_W-1:0] new_expiry = '0;
  logic strobe;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0]   timer_id_res;
  logic last;

  heap_timer_queue #(.CAPACITY(CAP)) dut (
    .clk, .rst, .start, .busy, .command, .now, .time_slot, .timer_id,
    .new_expiry, .strobe, .kind, .timer_id_res, .last
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Predictor state: a copy of the heap, its count and the last id issued.
  logic [EXP_W-1:0] pq_exp [CAP];
  logic [ID_W-1:0]  pq_id [CAP];
  int unsigned      pq_count = 0;
  logic [ID_W-1:0]  last_issued = '0;

  command_t pending_cmds[$];
  outcome_t awaited[$];
  int mismatches = 0;
  int results_seen = 0;
  int cmds_sent = 0;
  bit stim_done = 1'b0;

  function automatic void swap_slots(int a, int b);
    logic [EXP_W-1:0] e;
    logic [ID_W-1:0] d;
    e = pq_exp[a]; d = pq_id[a];
    pq_exp[a] = pq_exp[b]; pq_id[a] = pq_id[b];
    pq_exp[b] = e; pq_id[b] = d;
  endfunction

  function automatic void bubble_up(int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!(pq_exp[i] < pq_exp[p])) break;
      swap_slots(i, p);
      i = p;
    end
  endfunction

  function automatic void bubble_down(int i, int n);
    int c;
    while (i < n) begin
      c = 2 * i + 1;
      if (c >= n) break;
      if (c + 1 < n && pq_exp[c + 1] < pq_exp[c]) c++;
      if (pq_exp[i] < pq_exp[c]) break;
      swap_slots(i, c);
      i = c;
    end
  endfunction

  function automatic void drop_slot(int i);
    int n;
    n = pq_count - 1;
    if (i != n) begin
      swap_slots(i, n);
      bubble_down(i, n);
      bubble_up(i);
    end
    pq_count = n;
  endfunction

  function automatic int locate(logic [ID_W-1:0] ident);
    for (int k = 0; k < pq_count; k++)
      if (pq_id[k] == ident) return k;
    return -1;
  endfunction

  function automatic void expect_result(logic [KIND_W-1:0] k, logic [ID_W-1:0] d, logic l);
    outcome_t o;
    o.kind = k; o.ident = d; o.last = l;
    awaited = {awaited, o};
  endfunction

  // Applies one accepted command to the predicted heap and queues its results.
  function automatic void predict_timers(command_t c);
    logic [EXP_W:0] sum;
    logic [ID_W-1:0] nid;
    int pos;
    int fired;
    case (c.cmd)
      CMD_ADD: begin
        if (pq_count >= CAP) begin
          expect_result(KIND_FULL, '0, 1'b1);
        end else begin
          sum = {1'b0, c.at} + {1'b0, c.span};
          nid = last_issued + 1'b1;
          if (nid == '0) nid = ID_W'(1);
          last_issued = nid;
          pq_exp[pq_count] = sum[EXP_W] ? '1 : sum[EXP_W-1:0];
          pq_id[pq_count] = nid;
          pq_count++;
          bubble_up(pq_count - 1);
          expect_result(KIND_ADDED, nid, 1'b1);
        end
      end
      CMD_DELETE, CMD_FIRE: begin
        pos = locate(c.ident);
        if (pos < 0) begin
          expect_result(KIND_NOTFOUND, '0, 1'b1);
        end else begin
          drop_slot(pos);
          expect_result(c.cmd == CMD_DELETE ? KIND_DELETED : KIND_FIRED, c.ident, 1'b1);
        end
      end
      CMD_ADJUST: begin
        pos = locate(c.ident);
        if (pos < 0) begin
          expect_result(KIND_NOTFOUND, '0, 1'b1);
        end else begin
          pq_exp[pos] = c.expiry;
          bubble_up(pos);
          bubble_down(pos, pq_count);
          expect_result(KIND_ADJUSTED, c.ident, 1'b1);
        end
      end
      CMD_TICK: begin
        fired = 0;
        while (pq_count > 0 && !(c.at < pq_exp[0])) begin
          expect_result(KIND_FIRED, pq_id[0], 1'b0);
          drop_slot(0);
          fired++;
        end
        if (fired == 0) expect_result(KIND_NONE, '0, 1'b1);
        else awaited[$].last = 1'b1;
      end
      CMD_CLEAR: begin
        pq_count = 0;
        expect_result(KIND_CLEARED, '0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Driver: presents queued commands at the falling edge, holds them until taken.
  // A transaction counts as taken once the monitor has counted it.
  int gap = 0;
  int cmds_issued = 0;
  always @(negedge clk) begin
    bit idle_now;
    if (rst) begin
      start <= 1'b0;
    end else begin
      idle_now = !start;
      if (start && cmds_sent == cmds_issued) begin
        idle_now = 1'b1;
        gap = pick_gap();
      end
      if (idle_now) begin
        if (gap > 0) begin
          gap = gap - 1;
          start <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          command    <= pending_cmds[0].cmd;
          now        <= pending_cmds[0].at;
          time_slot  <= pending_cmds[0].span;
          timer_id   <= pending_cmds[0].ident;
          new_expiry <= pending_cmds[0].expiry;
          start      <= 1'b1;
          cmds_issued++;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Acceptance and result checking both happen at the rising edge.
  always @(posedge clk) begin
    outcome_t e;
    if (!rst && start && !busy) begin
      predict_timers(pending_cmds.pop_front());
      cmds_sent++;
    end
    if (!rst && strobe) begin
      results_seen++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result kind=%0d id=%0d last=%0b", kind, timer_id_res, last);
      end else begin
        e = awaited.pop_front();
        if (e.kind !== kind || e.ident !== timer_id_res || e.last !== last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected kind=%0d id=%0d last=%0b, got kind=%0d id=%0d last=%0b",
                     e.kind, e.ident, e.last, kind, timer_id_res, last);
        end
      end
    end
  end

  function automatic void queue_cmd(logic [CMD_W-1:0] c, logic [EXP_W-1:0] t,
                                    logic [EXP_W-1:0] s, logic [ID_W-1:0] d,
                                    logic [EXP_W-1:0] x);
    command_t m;
    m.cmd = c; m.at = t; m.span = s; m.ident = d; m.expiry = x;
    pending_cmds = {pending_cmds, m};
  endfunction

  // Stimulus: directed corners first, then random work around a moving clock.
  initial begin
    logic [EXP_W-1:0] clock_now;
    logic [ID_W-1:0] pick;
    int r;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    queue_cmd(CMD_TICK, '0, '0, '0, '0);               // nothing due on an empty heap
    queue_cmd(CMD_ADD, 32'd100, 32'd50, ID_MAX, '1);
    queue_cmd(CMD_ADD, '1, '1, '0, '0);                // saturating expiry
    queue_cmd(CMD_ADD, 32'd10, '0, '0, '0);
    queue_cmd(CMD_ADD, 32'd10, '0, '0, '0);            // equal expiries
    queue_cmd(CMD_DELETE, '0, '0, 31'd1, '0);
    queue_cmd(CMD_DELETE, '0, '0, ID_MAX, '0);         // unknown id
    queue_cmd(CMD_ADJUST, '0, '0, 31'd2, '0);          // adjust moves up
    queue_cmd(CMD_ADJUST, '0, '0, 31'd2, '1);          // adjust moves down
    queue_cmd(CMD_ADJUST, '0, '0, 31'd99, 32'd5);      // adjust unknown id
    queue_cmd(CMD_FIRE, '0, '0, 31'd3, '0);
    queue_cmd(CMD_FIRE, '0, '0, 31'd3, '0);            // fire again: gone
    queue_cmd(3'd6, '1, '1, ID_MAX, '1);               // unused commands
    queue_cmd(3'd7, '0, '0, '0, '0);
    queue_cmd(CMD_TICK, '1, '0, '0, '0);               // everything due
    for (int i = 0; i < CAP; i++) queue_cmd(CMD_ADD, 32'd7, i % 5, '0, '0);
    queue_cmd(CMD_ADD, '0, '0, '0, '0);                // full heap
    queue_cmd(CMD_TICK, 32'd9, '0, '0, '0);            // long tick burst
    queue_cmd(CMD_CLEAR, '0, '0, '0, '0);

    clock_now = 32'd1000;
    for (int i = 0; i < 150; i++) begin
      r = $urandom_range(0, 99);
      pick = $urandom_range(0, 99) < 80 ? ID_W'($urandom_range(1, CAP + 80)) :
             ID_W'($urandom);
      if (r < 38)
        queue_cmd(CMD_ADD, clock_now, $urandom_range(0, 9) == 0 ? {$urandom} :
                  $urandom_range(0, 400), ID_W'($urandom), {$urandom});
      else if (r < 50)
        queue_cmd(CMD_DELETE, {$urandom}, {$urandom}, pick, {$urandom});
      else if (r < 64)
        queue_cmd(CMD_ADJUST, {$urandom}, {$urandom}, pick,
                  $urandom_range(0, 5) == 0 ? {$urandom} : clock_now + $urandom_range(0, 400));
      else if (r < 72)
        queue_cmd(CMD_FIRE, {$urandom}, {$urandom}, pick, {$urandom});
      else if (r < 94) begin
        clock_now = clock_now + $urandom_range(0, 150);
        queue_cmd(CMD_TICK, clock_now, {$urandom}, ID_W'($urandom), {$urandom});
      end else if (r < 97)
        queue_cmd(CMD_CLEAR, {$urandom}, {$urandom}, ID_W'($urandom), {$urandom});
      else
        queue_cmd(CMD_W'($urandom_range(6, 7)), {$urandom}, {$urandom}, ID_W'($urandom),
                  {$urandom});
    end
    queue_cmd(CMD_TICK, '1, '0, '0, '0);

    wait (pending_cmds.size() == 0 && !start);
    wait (awaited.size() == 0);
    repeat (200) @(posedge clk);
    $display("Ran %0d commands and checked %0d results against the heap predictor.",
             cmds_sent, results_seen);
    if (mismatches == 0 && awaited.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Watchdog: a generous bound on the slowest correct run.
  initial begin
    #20ms;
    $display("Timed out with %0d results outstanding.", awaited.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
src/htq_pkg.sv
src/htq_ram.sv
src/htq_seq.sv
src/heap_timer_queue.sv
tb/tb.sv
